@@ hdl/incds_pkg.sv @@
`timescale 1ns / 1ps

package incds_pkg;

  // fixed widths of the result fields
  localparam int unsigned LineOutW = 24;

  // result queue geometry
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;
  localparam int unsigned FifoCntW  = 4;

  // character codes
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharQuote  = 8'h27;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharFf     = 8'h0C;
  localparam logic [7:0] CharVt     = 8'h0B;
  localparam logic [7:0] CharI      = 8'h69;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharC      = 8'h63;
  localparam logic [7:0] CharL      = 8'h6C;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharD      = 8'h64;
  localparam logic [7:0] CharE      = 8'h65;

  // directive recognizer states
  typedef enum logic [3:0] {
    ST_NONE    = 4'd0,
    ST_NEWLINE = 4'd1,
    ST_PREPROC = 4'd2,
    ST_I       = 4'd3,
    ST_IN      = 4'd4,
    ST_INC     = 4'd5,
    ST_INCL    = 4'd6,
    ST_INCLU   = 4'd7,
    ST_D       = 4'd8,
    ST_E       = 4'd9,
    ST_STRING  = 4'd10
  } scan_state_e;

  // lexical modes
  typedef enum logic [2:0] {
    MD_NORMAL  = 3'd0,
    MD_BSLASH  = 3'd1,
    MD_SLASH   = 3'd2,
    MD_BLOCK   = 3'd3,
    MD_LINE    = 3'd4,
    MD_LITERAL = 3'd5,
    MD_NAME    = 3'd6
  } scan_mode_e;

  // warning held until a literal closes
  typedef enum logic [1:0] {
    DW_NONE  = 2'd0,
    DW_UNREC = 2'd1,
    DW_END   = 2'd2
  } defer_e;

  typedef enum logic [1:0] {
    KIND_NAME_BYTE = 2'd0,
    KIND_NAME_END  = 2'd1,
    KIND_WARNING   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    WARN_EOF_STRING  = 3'd0,
    WARN_EOL_STRING  = 3'd1,
    WARN_EOF_COMMENT = 3'd2,
    WARN_UNREC       = 3'd3,
    WARN_END_EXPECT  = 3'd4
  } warn_e;

  typedef struct packed {
    scan_state_e state;
    scan_mode_e  mode;
    logic        star_seen;
    logic        literal_double;
    logic        escape_pending;
    logic        name_is_angled;
    defer_e      deferred;
  } scan_t;

  localparam scan_t ScanReset = '{
    state:          ST_NEWLINE,
    mode:           MD_NORMAL,
    star_seen:      1'b0,
    literal_double: 1'b0,
    escape_pending: 1'b0,
    name_is_angled: 1'b0,
    deferred:       DW_NONE
  };

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           name_char;
    logic                 angled;
    warn_e                code;
    logic [LineOutW-1:0]  line_number;
    logic                 last;
  } result_t;

  // results of one item handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_res(kind_e k, logic [7:0] ch, logic ang, warn_e w);
    result_t r;
    r           = '0;
    r.kind      = k;
    r.name_char = ch;
    r.angled    = ang;
    r.code      = w;
    return r;
  endfunction

endpackage

@@ hdl/incds_scan.sv @@
`timescale 1ns / 1ps

module incds_scan #(
  parameter int unsigned LINE_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_file_i,
  output incds_pkg::push_t push_o
);

  incds_pkg::scan_t     st_q, st_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  incds_pkg::result_t   r0, r1;
  logic [1:0]           n_res;
  logic                 bump;

  // one byte of scanning, emissions in source order
  always_comb begin : p_step
    incds_pkg::scan_t   s;
    logic [1:0]         n;
    logic [7:0]         c;
    logic               pre_stray;
    logic               do_norm;
    logic               norm_stray;
    incds_pkg::result_t res [2];
    s          = st_q;
    n          = 2'd0;
    c          = data_byte_i;
    pre_stray  = 1'b0;
    do_norm    = 1'b0;
    norm_stray = 1'b0;
    bump       = 1'b0;
    res[0]     = '0;
    res[1]     = '0;

    if (end_of_file_i) begin
      // flush whatever is open at end of file
      unique case (s.mode)
        incds_pkg::MD_BSLASH, incds_pkg::MD_SLASH: pre_stray = 1'b1;
        incds_pkg::MD_BLOCK, incds_pkg::MD_LINE: begin
          res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                        incds_pkg::WARN_EOF_COMMENT);
          n = n + 2'd1;
        end
        incds_pkg::MD_LITERAL: begin
          res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                        incds_pkg::WARN_EOF_STRING);
          n = n + 2'd1;
          if (s.deferred == incds_pkg::DW_UNREC) begin
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                          incds_pkg::WARN_UNREC);
            n = n + 2'd1;
          end else if (s.deferred == incds_pkg::DW_END) begin
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                          incds_pkg::WARN_END_EXPECT);
            n = n + 2'd1;
          end
        end
        incds_pkg::MD_NAME: begin
          res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                        incds_pkg::WARN_EOF_STRING);
          n = n + 2'd1;
          res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_NAME_END, 8'h00,
                                        s.name_is_angled, incds_pkg::WARN_EOF_STRING);
          n = n + 2'd1;
        end
        default: ;
      endcase
    end else begin
      // mode dependent handling
      unique case (s.mode)
        incds_pkg::MD_BSLASH: begin
          s.mode = incds_pkg::MD_NORMAL;
          if (c == incds_pkg::CharLf) begin
            bump = 1'b1;
          end else begin
            pre_stray = 1'b1;
            do_norm   = 1'b1;
          end
        end
        incds_pkg::MD_SLASH: begin
          s.mode = incds_pkg::MD_NORMAL;
          if (c == incds_pkg::CharStar || c == incds_pkg::CharSlash) begin
            if (s.state >= incds_pkg::ST_I && s.state <= incds_pkg::ST_D) begin
              s.state = incds_pkg::ST_NONE;
            end
            if (c == incds_pkg::CharStar) begin
              s.star_seen = 1'b0;
              s.mode      = incds_pkg::MD_BLOCK;
            end else begin
              s.mode = incds_pkg::MD_LINE;
            end
          end else begin
            pre_stray = 1'b1;
            do_norm   = 1'b1;
          end
        end
        incds_pkg::MD_BLOCK: begin
          if (c == incds_pkg::CharLf) begin
            bump        = 1'b1;
            s.star_seen = 1'b0;
          end else if (c == incds_pkg::CharStar) begin
            s.star_seen = 1'b1;
          end else if (s.star_seen && c == incds_pkg::CharSlash) begin
            s.star_seen = 1'b0;
            s.mode      = incds_pkg::MD_NORMAL;
          end else begin
            s.star_seen = 1'b0;
          end
        end
        incds_pkg::MD_LINE: begin
          if (c == incds_pkg::CharLf) begin
            bump   = 1'b1;
            s.mode = incds_pkg::MD_NORMAL;
          end
        end
        incds_pkg::MD_LITERAL: begin
          if (s.escape_pending) begin
            s.escape_pending = 1'b0;
            if (c == incds_pkg::CharLf) bump = 1'b1;
          end else if (c == incds_pkg::CharLf ||
                       c == (s.literal_double ? incds_pkg::CharDquote
                                              : incds_pkg::CharQuote)) begin
            if (c == incds_pkg::CharLf) begin
              res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                            incds_pkg::WARN_EOL_STRING);
              n       = n + 2'd1;
              do_norm = 1'b1;
            end
            // close the literal, releasing any held warning
            if (s.deferred == incds_pkg::DW_UNREC) begin
              res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                            incds_pkg::WARN_UNREC);
              n = n + 2'd1;
            end else if (s.deferred == incds_pkg::DW_END) begin
              res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                            incds_pkg::WARN_END_EXPECT);
              n = n + 2'd1;
            end
            s.deferred       = incds_pkg::DW_NONE;
            s.escape_pending = 1'b0;
            s.mode           = incds_pkg::MD_NORMAL;
          end else if (c == incds_pkg::CharBslash) begin
            s.escape_pending = 1'b1;
          end
        end
        incds_pkg::MD_NAME: begin
          if (c == (s.name_is_angled ? incds_pkg::CharGt : incds_pkg::CharDquote)) begin
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_NAME_END, 8'h00,
                                          s.name_is_angled, incds_pkg::WARN_EOF_STRING);
            n      = n + 2'd1;
            s.mode = incds_pkg::MD_NORMAL;
          end else if (c == incds_pkg::CharLf) begin
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                          incds_pkg::WARN_EOL_STRING);
            n = n + 2'd1;
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_NAME_END, 8'h00,
                                          s.name_is_angled, incds_pkg::WARN_EOF_STRING);
            n       = n + 2'd1;
            s.mode  = incds_pkg::MD_NORMAL;
            do_norm = 1'b1;
          end else begin
            res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_NAME_BYTE, c,
                                          s.name_is_angled, incds_pkg::WARN_EOF_STRING);
            n = n + 2'd1;
          end
        end
        default: begin
          s.mode  = incds_pkg::MD_NORMAL;
          do_norm = 1'b1;
        end
      endcase
    end

    // stray character left by a lone backslash or slash
    if (pre_stray) begin
      if (s.state == incds_pkg::ST_E) begin
        res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                      incds_pkg::WARN_UNREC);
        n = n + 2'd1;
      end else if (s.state == incds_pkg::ST_STRING) begin
        res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                      incds_pkg::WARN_END_EXPECT);
        n = n + 2'd1;
      end
      s.state = incds_pkg::ST_NONE;
    end

    // plain source byte through the directive recognizer
    if (do_norm) begin
      unique case (c)
        incds_pkg::CharSpace, incds_pkg::CharTab, incds_pkg::CharFf, incds_pkg::CharVt: begin
          if (s.state >= incds_pkg::ST_I && s.state <= incds_pkg::ST_D) begin
            s.state = incds_pkg::ST_NONE;
          end
        end
        incds_pkg::CharLf: begin
          s.state = incds_pkg::ST_NEWLINE;
          bump    = 1'b1;
        end
        incds_pkg::CharBslash: s.mode = incds_pkg::MD_BSLASH;
        incds_pkg::CharSlash:  s.mode = incds_pkg::MD_SLASH;
        incds_pkg::CharHash: begin
          if (s.state == incds_pkg::ST_NEWLINE) s.state = incds_pkg::ST_PREPROC;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharI: begin
          if (s.state == incds_pkg::ST_PREPROC) s.state = incds_pkg::ST_I;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharN: begin
          if (s.state == incds_pkg::ST_I) s.state = incds_pkg::ST_IN;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharC: begin
          if (s.state == incds_pkg::ST_IN) s.state = incds_pkg::ST_INC;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharL: begin
          if (s.state == incds_pkg::ST_INC) s.state = incds_pkg::ST_INCL;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharU: begin
          if (s.state == incds_pkg::ST_INCL) s.state = incds_pkg::ST_INCLU;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharD: begin
          if (s.state == incds_pkg::ST_INCLU) s.state = incds_pkg::ST_D;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharE: begin
          if (s.state == incds_pkg::ST_D) s.state = incds_pkg::ST_E;
          else norm_stray = 1'b1;
        end
        incds_pkg::CharLt: begin
          if (s.state == incds_pkg::ST_E) begin
            s.name_is_angled = 1'b1;
            s.state          = incds_pkg::ST_STRING;
            s.mode           = incds_pkg::MD_NAME;
          end else begin
            norm_stray = 1'b1;
          end
        end
        incds_pkg::CharDquote, incds_pkg::CharQuote: begin
          if (c == incds_pkg::CharDquote && s.state == incds_pkg::ST_E) begin
            s.name_is_angled = 1'b0;
            s.state          = incds_pkg::ST_STRING;
            s.mode           = incds_pkg::MD_NAME;
          end else begin
            // open a literal, holding the warning its quote earns
            if (s.state == incds_pkg::ST_E) s.deferred = incds_pkg::DW_UNREC;
            else if (s.state == incds_pkg::ST_STRING) s.deferred = incds_pkg::DW_END;
            else s.deferred = incds_pkg::DW_NONE;
            s.state          = incds_pkg::ST_NONE;
            s.literal_double = (c == incds_pkg::CharDquote);
            s.escape_pending = 1'b0;
            s.mode           = incds_pkg::MD_LITERAL;
          end
        end
        default: norm_stray = 1'b1;
      endcase
    end

    // stray character within a directive
    if (norm_stray) begin
      if (s.state == incds_pkg::ST_E) begin
        res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                      incds_pkg::WARN_UNREC);
        n = n + 2'd1;
      end else if (s.state == incds_pkg::ST_STRING) begin
        res[n[0]] = incds_pkg::mk_res(incds_pkg::KIND_WARNING, 8'h00, 1'b0,
                                      incds_pkg::WARN_END_EXPECT);
        n = n + 2'd1;
      end
      s.state = incds_pkg::ST_NONE;
    end

    if (end_of_file_i) s = incds_pkg::ScanReset;

    st_d  = s;
    n_res = n;
    r0    = res[0];
    r1    = res[1];
  end

  // saturating line counter, restarts at line one after end of file
  always_comb begin
    line_d = line_q;
    if (end_of_file_i) begin
      line_d = LINE_BITS'(1);
    end else if (bump && line_q != '1) begin
      line_d = line_q + LINE_BITS'(1);
    end
  end

  // results carry the line count as it stood before this byte
  always_comb begin
    push_o                = '0;
    push_o.count          = item_valid_i ? n_res : 2'd0;
    push_o.r0             = r0;
    push_o.r0.line_number = incds_pkg::LineOutW'(line_q);
    push_o.r0.last        = (n_res == 2'd1);
    push_o.r1             = r1;
    push_o.r1.line_number = incds_pkg::LineOutW'(line_q);
    push_o.r1.last        = 1'b1;
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= incds_pkg::ScanReset;
      line_q <= LINE_BITS'(1);
    end else if (item_valid_i) begin
      st_q   <= st_d;
      line_q <= line_d;
    end
  end

endmodule

@@ hdl/incds_ofifo.sv @@
`timescale 1ns / 1ps

module incds_ofifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  incds_pkg::push_t                   push_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output incds_pkg::result_t                 res_o,
  output logic [incds_pkg::FifoCntW-1:0]     count_o
);

  incds_pkg::result_t                  mem [incds_pkg::FifoDepth];
  logic [incds_pkg::FifoPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [incds_pkg::FifoCntW-1:0]      cnt_q, cnt_d;
  logic                                pop;

  assign res_valid_o = (cnt_q != '0);
  assign pop         = res_valid_o && res_ready_i;
  assign res_o       = mem[rd_q];
  assign count_o     = cnt_q;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q + incds_pkg::FifoPtrW'(push_i.count);
    rd_d  = rd_q + incds_pkg::FifoPtrW'(pop);
    cnt_d = cnt_q + incds_pkg::FifoCntW'(push_i.count) - incds_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // up to two results written per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem[wr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem[wr_q + incds_pkg::FifoPtrW'(1)] <= push_i.r1;
  end

endmodule

@@ hdl/include_directive_scanner.sv @@
`timescale 1ns / 1ps
// path: a byte transfer is held in the input register, then its results are written to the result queue
// throughput: one byte per cycle while the result queue has room; a byte that yields two results
// is read out as two transfers, set by the single read port of the eight-entry result queue
// reset: asynchronous active low; scanner at line start, line count one, queue empty
// an end-of-file transfer flushes open constructs and restarts the count at line one

module include_directive_scanner #(
  parameter int unsigned LINE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // end_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // name_char, angled, warning_code, line_number, zero pad
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // last_of_run
);

  logic                              in_valid_q;
  logic [7:0]                        in_byte_q;
  logic                              in_eof_q;
  logic                              s_xfer;
  incds_pkg::push_t                  push;
  incds_pkg::result_t                res;
  logic [incds_pkg::FifoCntW-1:0]    q_count;

  // room for the item in flight and the next one
  assign s_axis_tready_o = (q_count + incds_pkg::FifoCntW'({in_valid_q, 1'b0}))
                           <= incds_pkg::FifoCntW'(incds_pkg::FifoDepth - 2);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= s_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_eof_q  <= s_axis_tlast_i;
    end
  end

  incds_scan #(
    .LINE_BITS(LINE_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .data_byte_i  (in_byte_q),
    .end_of_file_i(in_eof_q),
    .push_o       (push)
  );

  incds_ofifo u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res),
    .count_o    (q_count)
  );

  // output packing
  assign m_axis_tdata_o = {4'b0000, res.line_number, res.code, res.angled, res.name_char};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // no idling once the source queue is down to this many bytes
  localparam int unsigned QuietLen = 200;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } src_item_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  src_item_t            src_q[$];
  incds_pkg::result_t   scan_results_q[$];
  int unsigned err_cnt   = 0;
  int unsigned bytes_in  = 0;
  logic        in_fire   = 1'b0;
  int unsigned src_gap   = 0;
  int unsigned sink_gap  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  include_directive_scanner u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // data_byte
    .s_axis_tlast_i  (s_last),   // end_of_file
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // name_char, angled, warning_code, line_number, zero pad
    .m_axis_tuser_o  (m_user),   // kind
    .m_axis_tlast_o  (m_last)    // last_of_run
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as the prediction sees it
  incds_pkg::scan_state_e         sc_state = incds_pkg::ST_NEWLINE;
  incds_pkg::scan_mode_e          sc_mode  = incds_pkg::MD_NORMAL;
  logic                           sc_star  = 1'b0;
  logic                           sc_dbl   = 1'b0;
  logic                           sc_esc   = 1'b0;
  logic                           sc_ang   = 1'b0;
  incds_pkg::defer_e              sc_defer = incds_pkg::DW_NONE;
  logic [incds_pkg::LineOutW-1:0] sc_line  = incds_pkg::LineOutW'(1);

  incds_pkg::result_t step_res[2];
  int unsigned        step_n;

  task automatic put_result(incds_pkg::kind_e k, logic [7:0] ch, logic ang,
                            incds_pkg::warn_e w);
    incds_pkg::result_t r;
    r             = '0;
    r.kind        = k;
    r.name_char   = ch;
    r.angled      = ang;
    r.code        = w;
    r.line_number = sc_line;
    if (step_n < 2) begin
      step_res[step_n] = r;
      step_n++;
    end
  endtask

  task automatic put_warning(incds_pkg::warn_e w);
    put_result(incds_pkg::KIND_WARNING, 8'h00, 1'b0, w);
  endtask

  task automatic bump_line();
    if (sc_line != '1) sc_line = sc_line + incds_pkg::LineOutW'(1);
  endtask

  // byte that does not continue a directive
  task automatic stray_byte();
    if (sc_state == incds_pkg::ST_E) put_warning(incds_pkg::WARN_UNREC);
    else if (sc_state == incds_pkg::ST_STRING) put_warning(incds_pkg::WARN_END_EXPECT);
    sc_state = incds_pkg::ST_NONE;
  endtask

  task automatic break_word();
    if (sc_state >= incds_pkg::ST_I && sc_state <= incds_pkg::ST_D) begin
      sc_state = incds_pkg::ST_NONE;
    end
  endtask

  task automatic open_literal(logic dbl);
    if (sc_state == incds_pkg::ST_E) sc_defer = incds_pkg::DW_UNREC;
    else if (sc_state == incds_pkg::ST_STRING) sc_defer = incds_pkg::DW_END;
    else sc_defer = incds_pkg::DW_NONE;
    sc_state = incds_pkg::ST_NONE;
    sc_dbl   = dbl;
    sc_esc   = 1'b0;
    sc_mode  = incds_pkg::MD_LITERAL;
  endtask

  // held directive warning comes out when the literal ends
  task automatic close_literal();
    if (sc_defer == incds_pkg::DW_UNREC) put_warning(incds_pkg::WARN_UNREC);
    else if (sc_defer == incds_pkg::DW_END) put_warning(incds_pkg::WARN_END_EXPECT);
    sc_defer = incds_pkg::DW_NONE;
    sc_esc   = 1'b0;
    sc_mode  = incds_pkg::MD_NORMAL;
  endtask

  task automatic open_name(logic ang);
    sc_ang   = ang;
    sc_state = incds_pkg::ST_STRING;
    sc_mode  = incds_pkg::MD_NAME;
  endtask

  task automatic advance(incds_pkg::scan_state_e need, incds_pkg::scan_state_e nxt);
    if (sc_state == need) sc_state = nxt;
    else stray_byte();
  endtask

  task automatic plain_byte(logic [7:0] c);
    case (c)
      incds_pkg::CharSpace, incds_pkg::CharTab, incds_pkg::CharFf, incds_pkg::CharVt:
        break_word();
      incds_pkg::CharLf: begin
        sc_state = incds_pkg::ST_NEWLINE;
        bump_line();
      end
      incds_pkg::CharBslash: sc_mode = incds_pkg::MD_BSLASH;
      incds_pkg::CharSlash:  sc_mode = incds_pkg::MD_SLASH;
      incds_pkg::CharHash:   advance(incds_pkg::ST_NEWLINE, incds_pkg::ST_PREPROC);
      incds_pkg::CharI:      advance(incds_pkg::ST_PREPROC, incds_pkg::ST_I);
      incds_pkg::CharN:      advance(incds_pkg::ST_I, incds_pkg::ST_IN);
      incds_pkg::CharC:      advance(incds_pkg::ST_IN, incds_pkg::ST_INC);
      incds_pkg::CharL:      advance(incds_pkg::ST_INC, incds_pkg::ST_INCL);
      incds_pkg::CharU:      advance(incds_pkg::ST_INCL, incds_pkg::ST_INCLU);
      incds_pkg::CharD:      advance(incds_pkg::ST_INCLU, incds_pkg::ST_D);
      incds_pkg::CharE:      advance(incds_pkg::ST_D, incds_pkg::ST_E);
      incds_pkg::CharLt: begin
        if (sc_state == incds_pkg::ST_E) open_name(1'b1);
        else stray_byte();
      end
      incds_pkg::CharDquote: begin
        if (sc_state == incds_pkg::ST_E) open_name(1'b0);
        else open_literal(1'b1);
      end
      incds_pkg::CharQuote: open_literal(1'b0);
      default:              stray_byte();
    endcase
  endtask

  // end of file: close whatever is open, then back to line one
  task automatic flush_file();
    case (sc_mode)
      incds_pkg::MD_BSLASH, incds_pkg::MD_SLASH: stray_byte();
      incds_pkg::MD_BLOCK, incds_pkg::MD_LINE:   put_warning(incds_pkg::WARN_EOF_COMMENT);
      incds_pkg::MD_LITERAL: begin
        put_warning(incds_pkg::WARN_EOF_STRING);
        close_literal();
      end
      incds_pkg::MD_NAME: begin
        put_warning(incds_pkg::WARN_EOF_STRING);
        put_result(incds_pkg::KIND_NAME_END, 8'h00, sc_ang, incds_pkg::WARN_EOF_STRING);
      end
      default: ;
    endcase
    sc_state = incds_pkg::ST_NEWLINE;
    sc_mode  = incds_pkg::MD_NORMAL;
    sc_star  = 1'b0;
    sc_dbl   = 1'b0;
    sc_esc   = 1'b0;
    sc_ang   = 1'b0;
    sc_defer = incds_pkg::DW_NONE;
    sc_line  = incds_pkg::LineOutW'(1);
  endtask

  // results caused by one source byte, queued in order
  task automatic scan_source_byte(logic [7:0] c, logic eof);
    step_n = 0;
    if (eof) begin
      flush_file();
    end else begin
      case (sc_mode)
        incds_pkg::MD_BSLASH: begin
          sc_mode = incds_pkg::MD_NORMAL;
          if (c == incds_pkg::CharLf) begin
            bump_line();
          end else begin
            stray_byte();
            plain_byte(c);
          end
        end
        incds_pkg::MD_SLASH: begin
          sc_mode = incds_pkg::MD_NORMAL;
          if (c == incds_pkg::CharStar) begin
            break_word();
            sc_star = 1'b0;
            sc_mode = incds_pkg::MD_BLOCK;
          end else if (c == incds_pkg::CharSlash) begin
            break_word();
            sc_mode = incds_pkg::MD_LINE;
          end else begin
            stray_byte();
            plain_byte(c);
          end
        end
        incds_pkg::MD_BLOCK: begin
          if (c == incds_pkg::CharLf) begin
            bump_line();
            sc_star = 1'b0;
          end else if (c == incds_pkg::CharStar) begin
            sc_star = 1'b1;
          end else if (sc_star && c == incds_pkg::CharSlash) begin
            sc_star = 1'b0;
            sc_mode = incds_pkg::MD_NORMAL;
          end else begin
            sc_star = 1'b0;
          end
        end
        incds_pkg::MD_LINE: begin
          if (c == incds_pkg::CharLf) begin
            bump_line();
            sc_mode = incds_pkg::MD_NORMAL;
          end
        end
        incds_pkg::MD_LITERAL: begin
          if (sc_esc) begin
            sc_esc = 1'b0;
            if (c == incds_pkg::CharLf) bump_line();
          end else if (c == incds_pkg::CharLf) begin
            put_warning(incds_pkg::WARN_EOL_STRING);
            close_literal();
            plain_byte(c);
          end else if (c == incds_pkg::CharBslash) begin
            sc_esc = 1'b1;
          end else if (c == (sc_dbl ? incds_pkg::CharDquote : incds_pkg::CharQuote)) begin
            close_literal();
          end
        end
        incds_pkg::MD_NAME: begin
          if (c == (sc_ang ? incds_pkg::CharGt : incds_pkg::CharDquote)) begin
            put_result(incds_pkg::KIND_NAME_END, 8'h00, sc_ang, incds_pkg::WARN_EOF_STRING);
            sc_mode = incds_pkg::MD_NORMAL;
          end else if (c == incds_pkg::CharLf) begin
            put_warning(incds_pkg::WARN_EOL_STRING);
            put_result(incds_pkg::KIND_NAME_END, 8'h00, sc_ang, incds_pkg::WARN_EOF_STRING);
            sc_mode = incds_pkg::MD_NORMAL;
            plain_byte(c);
          end else begin
            put_result(incds_pkg::KIND_NAME_BYTE, c, sc_ang, incds_pkg::WARN_EOF_STRING);
          end
        end
        default: begin
          sc_mode = incds_pkg::MD_NORMAL;
          plain_byte(c);
        end
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int unsigned i = 0; i < step_n; i++) scan_results_q.push_back(step_res[i]);
  endtask

  // source text building
  task automatic push_byte(logic [7:0] b);
    src_item_t it;
    it.eof  = 1'b0;
    it.data = b;
    src_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_eof();
    src_item_t it;
    it.eof  = 1'b1;
    it.data = 8'($urandom_range(0, 255));
    src_q.push_back(it);
  endtask

  function automatic logic [7:0] pick(string a);
    return a[$urandom_range(0, a.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return incds_pkg::CharSpace;
      1:       return incds_pkg::CharTab;
      2:       return incds_pkg::CharFf;
      default: return incds_pkg::CharVt;
    endcase
  endfunction

  task automatic push_blanks();
    int unsigned n;
    n = $urandom_range(0, 2);
    repeat (n) push_byte(blank_char());
  endtask

  // include line with random name, sometimes broken on purpose
  task automatic push_directive();
    string       word;
    int unsigned cut;
    int unsigned n;
    int unsigned sel;
    logic [7:0]  closer;
    word = "include";
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 7;
    push_blanks();
    push_byte(incds_pkg::CharHash);
    push_blanks();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0) push_text("\\\n");
      push_byte(word[i]);
    end
    push_blanks();
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      push_byte(incds_pkg::CharLt);
      closer = incds_pkg::CharGt;
    end else if (sel < 8) begin
      push_byte(incds_pkg::CharDquote);
      closer = incds_pkg::CharDquote;
    end else if (sel == 8) begin
      push_byte(incds_pkg::CharQuote);
      closer = incds_pkg::CharQuote;
    end else begin
      push_byte(pick("x>;(/\\"));
      closer = incds_pkg::CharLf;
    end
    n = $urandom_range(0, 6);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(pick("abcxyz./_-"));
    end
    if ($urandom_range(0, 7) != 0) push_byte(closer);
    case ($urandom_range(0, 9))
      6, 7:    push_byte(pick("x;>'\"\\/#"));
      8:       push_text(" // tail");
      9:       push_text(" /* c */");
      default: ;
    endcase
    push_byte(incds_pkg::CharLf);
  endtask

  task automatic push_random_run();
    int unsigned n;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      push_directive();
    end else if (sel < 60) begin
      if ($urandom_range(0, 1) == 0) begin
        push_text("/*");
        n = $urandom_range(0, 10);
        repeat (n) push_byte(pick("ab*/\n #"));
        if ($urandom_range(0, 5) != 0) push_text("*/");
      end else begin
        push_text("//");
        n = $urandom_range(0, 8);
        repeat (n) push_byte(pick("ab*/\\ #\"'"));
        push_byte(incds_pkg::CharLf);
      end
    end else if (sel < 75) begin
      push_byte(($urandom_range(0, 1) == 0) ? incds_pkg::CharQuote : incds_pkg::CharDquote);
      n = $urandom_range(0, 8);
      repeat (n) push_byte(pick("ab\\\"'\n #<"));
      push_byte(pick("\"'\n"));
    end else if (sel < 90) begin
      n = $urandom_range(1, 12);
      repeat (n) push_byte(pick("#include<>\"'/*\\ \n\tabx"));
    end else if (sel < 97) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_eof();
    end
  endtask

  // accepted byte transfers feed the prediction
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready) begin
      scan_source_byte(s_data, s_last);
      bytes_in++;
      in_fire = 1'b1;
    end else begin
      in_fire = 1'b0;
    end
  end

  // source driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) void'(src_q.pop_front());
      if (!s_valid || in_fire) begin
        if (src_gap > 0) begin
          src_gap--;
          s_valid <= 1'b0;
        end else if (src_q.size() > QuietLen && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 6);
          s_valid <= 1'b0;
        end else if (src_q.size() != 0) begin
          s_valid <= 1'b1;
          s_data  <= src_q[0].data;
          s_last  <= src_q[0].eof;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result sink: random stalls plus one long hold to back up the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!hold_done && bytes_in >= 500) begin
      hold_done = 1'b1;
      hold_left = 119;
      m_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_ready <= 1'b0;
    end else if (src_q.size() > QuietLen && $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(0, 6);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    incds_pkg::result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (scan_results_q.size() == 0) begin
        $display("%0t: result expected none actual kind %0h data %0h last %0b",
                 $time, m_user, m_data, m_last);
        err_cnt++;
      end else begin
        want = scan_results_q.pop_front();
        if (m_user !== want.kind) begin
          $display("%0t: kind expected %0h actual %0h", $time, want.kind, m_user);
          err_cnt++;
        end
        if (m_data[7:0] !== want.name_char) begin
          $display("%0t: name_char expected %0h actual %0h",
                   $time, want.name_char, m_data[7:0]);
          err_cnt++;
        end
        if (m_data[8] !== want.angled) begin
          $display("%0t: angled expected %0b actual %0b", $time, want.angled, m_data[8]);
          err_cnt++;
        end
        if (m_data[11:9] !== want.code) begin
          $display("%0t: warning_code expected %0d actual %0d",
                   $time, want.code, m_data[11:9]);
          err_cnt++;
        end
        if (m_data[35:12] !== want.line_number) begin
          $display("%0t: line_number expected %0d actual %0d",
                   $time, want.line_number, m_data[35:12]);
          err_cnt++;
        end
        if (m_last !== want.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, m_last);
          err_cnt++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // angled name with extreme bytes
    push_text("#include <");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text(">\n");
    // blanks around the hash, quoted name, then stray byte after the name
    push_byte(incds_pkg::CharSpace);
    push_byte(incds_pkg::CharVt);
    push_text("#");
    push_byte(incds_pkg::CharFf);
    push_text(" include \"q>\"x\n");
    // unrecognised directive, literal held behind a directive, newline in literal
    push_text("#include x\n#include 'a' \"b\n");
    // newline inside a name
    push_text("#include \"ab\n");
    // lone slash, block comment, joined line, line comment
    push_text("x/y/*a*b**/ #\\\ninclude<z>//c\n");
    // lone backslash after the keyword, escapes in literals
    push_text("#include\\x\n'\\''\"\\\"\"\n");
    // end of file in a block comment, literal, name, after a lone slash and in a line comment
    push_text("/*");
    push_eof();
    push_text("\"s");
    push_eof();
    push_text("#include<a");
    push_eof();
    push_text("#include/");
    push_eof();
    push_text("//");
    push_eof();
    push_eof();
    while (src_q.size() < 1300) push_random_run();
    push_eof();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || scan_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("include_directive_scanner: match");
    end else begin
      $display("include_directive_scanner: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("include_directive_scanner: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
hdl/incds_pkg.sv
hdl/incds_scan.sv
hdl/incds_ofifo.sv
hdl/include_directive_scanner.sv
bench/testbench.sv
